// ----- rtl/bc7_endpoint_quantize_index_error_assert.svh -----
// Assertion macros shared by the BC7 index selection block.
`ifndef BC7_ENDPOINT_QUANTIZE_INDEX_ERROR_ASSERT_SVH
`define BC7_ENDPOINT_QUANTIZE_INDEX_ERROR_ASSERT_SVH

// Same-cycle implication, checked on aclk outside reset.
`define BC7QIE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk outside reset.
`define BC7QIE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bc7qie_pkg.sv -----
// Types and constants shared by the BC7 index selection modules.
package bc7qie_pkg;

    localparam int InWidth    = 136;
    localparam int OutWidth   = 88;
    localparam int CfgAddrW   = 2;
    localparam int WeightW    = 9;
    localparam int DivSteps   = 22;
    localparam int CntW       = 5;

    localparam logic [CfgAddrW-1:0] RegWeightRed   = 2'd0;
    localparam logic [CfgAddrW-1:0] RegWeightGreen = 2'd1;
    localparam logic [CfgAddrW-1:0] RegWeightBlue  = 2'd2;
    localparam logic [CfgAddrW-1:0] RegWeightAlpha = 2'd3;

    localparam logic [WeightW-1:0] WeightReset = 9'd256;

    typedef struct packed {
        logic load;
        logic capture;
        logic dot;
        logic num;
        logic div_init;
        logic div_step;
        logic cand_sel;
        logic e1;
        logic e2;
        logic e3;
        logic take_first;
        logic take_second;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic has_second;
        logic out_free;
    } dp_sts_t;

endpackage

// ----- rtl/bc7qie_ctrl.sv -----
// Controller sequencing load, projection, division and error evaluation.
module bc7qie_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tuser,
    output logic               s_tready,
    input  bc7qie_pkg::dp_sts_t sts,
    output bc7qie_pkg::dp_cmd_t cmd
);
    import bc7qie_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DOT, ST_NUM, ST_DINIT, ST_DIV, ST_E1, ST_E2, ST_E3, ST_PICK, ST_FIN
    } state_t;

    state_t          state_reg, state_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            second_reg, second_next;
    logic            accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        second_next = second_reg;
        cmd         = '0;
        cmd.cand_sel = second_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && !s_tuser) begin
                    cmd.load = 1'b1;
                end else if (accept) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DOT;
                end
            end
            ST_DOT: begin
                cmd.dot    = 1'b1;
                state_next = ST_NUM;
            end
            ST_NUM: begin
                cmd.num    = 1'b1;
                state_next = ST_DINIT;
            end
            ST_DINIT: begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                second_next  = 1'b0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CntW'(DivSteps - 1)) begin
                    state_next = ST_E1;
                end
            end
            ST_E1: begin
                cmd.e1     = 1'b1;
                state_next = ST_E2;
            end
            ST_E2: begin
                cmd.e2     = 1'b1;
                state_next = ST_E3;
            end
            ST_E3: begin
                cmd.e3     = 1'b1;
                state_next = ST_PICK;
            end
            ST_PICK: begin
                if (second_reg) begin
                    cmd.take_second = 1'b1;
                    state_next      = ST_FIN;
                end else begin
                    cmd.take_first = 1'b1;
                    if (sts.has_second) begin
                        second_next = 1'b1;
                        state_next  = ST_E1;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                // Wait here until the output register can take the result.
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            second_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            second_reg <= second_next;
        end
    end

endmodule

// ----- rtl/bc7qie_dp.sv -----
// Datapath: endpoint quantization, projection, divider and error units.
module bc7qie_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  bc7qie_pkg::dp_cmd_t                   cmd,
    output bc7qie_pkg::dp_sts_t                   sts,
    input  logic [bc7qie_pkg::InWidth-1:0]        s_tdata,
    input  logic                                  s_tlast,
    input  logic                                  cfg_we,
    input  logic [bc7qie_pkg::CfgAddrW-1:0]       cfg_addr,
    input  logic [bc7qie_pkg::WeightW-1:0]        cfg_wdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [bc7qie_pkg::OutWidth-1:0]       m_tdata,
    output logic                                  m_tlast
);
    import bc7qie_pkg::*;

    function automatic logic [7:0] absdiff8(input logic [7:0] x, input logic [7:0] y);
        return (x > y) ? x - y : y - x;
    endfunction

    function automatic logic [7:0] quant_ch(input logic [7:0] val, input logic [7:0] mask,
                                            input logic pe, input logic pb);
        logic [3:0]  prec;
        logic [15:0] step, lo, hi;
        logic [7:0]  res;
        prec = '0;
        for (int i = 0; i < 8; i++) begin
            prec = prec + 4'(mask[i]);
        end
        step = 16'd1 << (4'd8 - prec);
        lo   = {8'h00, val & mask};
        hi   = lo + step;
        if (pe) begin
            prec = prec + 4'd1;
            lo   = lo | (16'(pb) << (4'd8 - prec));
            hi   = hi | (16'(pb) << (4'd8 - prec));
        end
        // The p-bit can lift lo above the value; the step back may wrap.
        if (lo > {8'h00, val}) begin
            lo = lo - step;
            hi = hi - step;
        end
        lo = lo | (lo >> prec);
        hi = hi | (hi >> prec);
        if (mask == 8'hFF) begin
            res = val;
        end else if (mask == 8'h00) begin
            res = 8'hFF;
        end else if (absdiff8(val, lo[7:0]) < absdiff8(val, hi[7:0])) begin
            res = lo[7:0];
        end else begin
            res = hi[7:0];
        end
        return res;
    endfunction

    function automatic logic [6:0] interp_w(input logic [2:0] bits, input logic [3:0] j);
        logic [6:0] w;
        case (bits)
            3'd2: begin
                case (j[1:0])
                    2'd0: w = 7'd0;
                    2'd1: w = 7'd21;
                    2'd2: w = 7'd43;
                    default: w = 7'd64;
                endcase
            end
            3'd3: begin
                case (j[2:0])
                    3'd0: w = 7'd0;
                    3'd1: w = 7'd9;
                    3'd2: w = 7'd18;
                    3'd3: w = 7'd27;
                    3'd4: w = 7'd37;
                    3'd5: w = 7'd46;
                    3'd6: w = 7'd55;
                    default: w = 7'd64;
                endcase
            end
            default: begin
                case (j)
                    4'd0: w = 7'd0;
                    4'd1: w = 7'd4;
                    4'd2: w = 7'd9;
                    4'd3: w = 7'd13;
                    4'd4: w = 7'd17;
                    4'd5: w = 7'd21;
                    4'd6: w = 7'd26;
                    4'd7: w = 7'd30;
                    4'd8: w = 7'd34;
                    4'd9: w = 7'd38;
                    4'd10: w = 7'd43;
                    4'd11: w = 7'd47;
                    4'd12: w = 7'd51;
                    4'd13: w = 7'd55;
                    4'd14: w = 7'd60;
                    default: w = 7'd64;
                endcase
            end
        endcase
        return w;
    endfunction

    // Input field slices
    logic [31:0] in_ea, in_eb, in_mask, in_px;
    logic        in_pe, in_pa, in_pb;
    logic [2:0]  in_bits;
    assign in_ea   = s_tdata[31:0];
    assign in_eb   = s_tdata[63:32];
    assign in_mask = s_tdata[95:64];
    assign in_pe   = s_tdata[96];
    assign in_pa   = s_tdata[97];
    assign in_pb   = s_tdata[98];
    assign in_bits = s_tdata[101:99];
    assign in_px   = s_tdata[133:102];

    logic [WeightW-1:0] weight_reg [4];
    logic [31:0] qa_reg, qb_reg, px_reg;
    logic [2:0]  bits_reg;
    logic [43:0] total_reg;
    logic        last_reg;

    logic signed [19:0] dot_reg;
    logic [18:0]        lsq_reg;
    logic               neg_reg;
    logic [21:0]        mag_reg;
    logic [21:0]        quo_reg;
    logic [18:0]        rem_reg;

    logic [3:0]  jcur_reg, best_idx_reg;
    logic [7:0]  ip_reg [4];
    logic [16:0] e_reg [4];
    logic [35:0] err_reg, best_err_reg;

    logic        mv_reg;
    logic [3:0]  mi_reg;
    logic [35:0] me_reg;
    logic [43:0] mt_reg;
    logic        ml_reg;

    // Projection: dot product and squared length over the four channels.
    logic signed [19:0] dot_c;
    logic [18:0]        lsq_c;
    logic signed [8:0]  dba, dpa;
    always_comb begin
        dot_c = '0;
        lsq_c = '0;
        for (int k = 0; k < 4; k++) begin
            dba   = $signed({1'b0, qb_reg[8*k +: 8]}) - $signed({1'b0, qa_reg[8*k +: 8]});
            dpa   = $signed({1'b0, px_reg[8*k +: 8]}) - $signed({1'b0, qa_reg[8*k +: 8]});
            dot_c = dot_c + 20'(dpa * dba);
            lsq_c = lsq_c + 19'($unsigned(18'(dba * dba)));
        end
    end

    logic [3:0]         top;
    logic signed [24:0] num_c;
    logic [24:0]        num_mag;
    assign top     = 4'((5'd1 << bits_reg) - 5'd1);
    assign num_c   = 25'(dot_reg) * $signed({21'd0, top});
    assign num_mag = num_c[24] ? 25'(-num_c) : 25'(num_c);

    logic [19:0] shifted;
    logic [20:0] trial;
    assign shifted = {rem_reg, quo_reg[21]};
    assign trial   = {1'b0, shifted} - {2'b00, lsq_reg};

    // Candidate indices from the floor and ceiling of the quotient.
    logic [3:0] j1, j2, jsel;
    logic       trivial, big;
    assign trivial        = (lsq_reg == '0) || neg_reg;
    assign big            = (quo_reg >= 22'(top));
    assign j1             = trivial ? 4'd0 : (big ? top : quo_reg[3:0]);
    assign j2             = quo_reg[3:0] + 4'd1;
    assign sts.has_second = !trivial && !big && (rem_reg != '0);
    assign jsel           = cmd.cand_sel ? j2 : j1;

    logic [6:0] w1, w0;
    assign w1 = interp_w(bits_reg, jsel);
    assign w0 = 7'd64 - w1;

    logic [35:0] err_c;
    always_comb begin
        err_c = '0;
        for (int k = 0; k < 4; k++) begin
            err_c = err_c + 36'(e_reg[k] * e_reg[k]);
        end
    end

    logic [44:0] tsum;
    logic [43:0] tnew;
    assign tsum = {1'b0, total_reg} + {9'd0, best_err_reg};
    assign tnew = tsum[44] ? '1 : tsum[43:0];

    assign sts.out_free = !mv_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 4; k++) begin
                weight_reg[k] <= WeightReset;
            end
            qa_reg    <= '0;
            qb_reg    <= '0;
            bits_reg  <= 3'd2;
            total_reg <= '0;
            mv_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    RegWeightRed:   weight_reg[0] <= cfg_wdata;
                    RegWeightGreen: weight_reg[1] <= cfg_wdata;
                    RegWeightBlue:  weight_reg[2] <= cfg_wdata;
                    RegWeightAlpha: weight_reg[3] <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.load) begin
                for (int k = 0; k < 4; k++) begin
                    qa_reg[8*k +: 8] <= quant_ch(in_ea[8*k +: 8], in_mask[8*k +: 8],
                                                 in_pe, in_pa);
                    qb_reg[8*k +: 8] <= quant_ch(in_eb[8*k +: 8], in_mask[8*k +: 8],
                                                 in_pe, in_pb);
                end
                bits_reg  <= (in_bits < 3'd2) ? 3'd2 : ((in_bits > 3'd4) ? 3'd4 : in_bits);
                total_reg <= '0;
            end
            if (cmd.finish) begin
                total_reg <= tnew;
                mv_reg    <= 1'b1;
            end else if (m_tready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            px_reg   <= in_px;
            last_reg <= s_tlast;
        end
        if (cmd.dot) begin
            dot_reg <= dot_c;
            lsq_reg <= lsq_c;
        end
        if (cmd.num) begin
            neg_reg <= num_c[24];
            mag_reg <= num_mag[21:0];
        end
        if (cmd.div_init) begin
            quo_reg <= mag_reg;
            rem_reg <= '0;
        end
        if (cmd.div_step) begin
            if (!trial[20]) begin
                rem_reg <= trial[18:0];
                quo_reg <= {quo_reg[20:0], 1'b1};
            end else begin
                rem_reg <= shifted[18:0];
                quo_reg <= {quo_reg[20:0], 1'b0};
            end
        end
        if (cmd.e1) begin
            jcur_reg <= jsel;
            for (int k = 0; k < 4; k++) begin
                ip_reg[k] <= 8'((15'(qa_reg[8*k +: 8]) * 15'(w0)
                               + 15'(qb_reg[8*k +: 8]) * 15'(w1) + 15'd32) >> 6);
            end
        end
        if (cmd.e2) begin
            for (int k = 0; k < 4; k++) begin
                e_reg[k] <= 17'(absdiff8(px_reg[8*k +: 8], ip_reg[k])) * 17'(weight_reg[k]);
            end
        end
        if (cmd.e3) begin
            err_reg <= err_c;
        end
        if (cmd.take_first || (cmd.take_second && (err_reg < best_err_reg))) begin
            best_err_reg <= err_reg;
            best_idx_reg <= jcur_reg;
        end
        if (cmd.finish) begin
            mi_reg <= best_idx_reg;
            me_reg <= best_err_reg;
            mt_reg <= tnew;
            ml_reg <= last_reg;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {4'd0, mt_reg, me_reg, mi_reg};
    assign m_tlast  = ml_reg;

endmodule

// ----- rtl/bc7_endpoint_quantize_index_error.sv -----
// Top level of the BC7 endpoint quantization and index selection block.
//
// Input stream: s_tuser = 0 is a load request carrying two RGBA8 endpoints,
// the channel masks, p-bits and index width; it quantizes and stores the
// endpoints, clears the running total and gives no result. s_tuser = 1 is a
// pixel request; it gives one result on the m_ stream with the chosen index,
// the weighted squared error and the saturating running total.
// A load leaves the block idle for the next request. A pixel request runs
// projection, the numerator, the restoring divider and the three-stage
// error unit, which runs once for each candidate index tried, one or two;
// the result then waits for the output register.
// One pixel is in work at a time; s_tready is high only while idle.
// The result sits in an output register, so the next request is taken while
// it waits; if the receiver still stalls when the following pixel finishes,
// that pixel holds until the register is free.
// Weights are written through cfg_we, cfg_addr, cfg_wdata; the user must do
// so only while idle, as the block does not enforce it. After reset the
// weights are 1.0, endpoints zero, index width two bits and the total zero.
module bc7_endpoint_quantize_index_error (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // endpoint_a, endpoint_b, channel_mask, pbit_enable, pbit_a, pbit_b,
    // index_bits, pixel, zero fill
    input  logic [bc7qie_pkg::InWidth-1:0]        s_tdata,
    input  logic                                  s_tuser,  // cmd
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // index, pixel_error, total_error, zero fill
    output logic [bc7qie_pkg::OutWidth-1:0]       m_tdata,
    output logic                                  m_tlast,
    input  logic                                  cfg_we,
    input  logic [bc7qie_pkg::CfgAddrW-1:0]       cfg_addr,
    input  logic [bc7qie_pkg::WeightW-1:0]        cfg_wdata
);
    import bc7qie_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    bc7qie_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bc7qie_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

`include "bc7_endpoint_quantize_index_error_assert.svh"

    `BC7QIE_ASSERT_NEXT(a_pixel_busy, s_tvalid && s_tready && s_tuser, !s_tready, "pixel did not start")
    `BC7QIE_ASSERT_NEXT(a_load_idle, s_tvalid && s_tready && !s_tuser, s_tready, "load left idle")
    `BC7QIE_ASSERT_NOW(a_total_ge, m_tvalid, m_tdata[83:40] >= {8'd0, m_tdata[39:4]}, "total below pixel error")

endmodule

// ----- test/tb_bc7_endpoint_quantize_index_error.sv -----
// Self-checking testbench for the BC7 endpoint quantization and index selection block.
module tb_bc7_endpoint_quantize_index_error;
    import bc7qie_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam bit CmdLoad  = 1'b0;
    localparam bit CmdPixel = 1'b1;
    localparam int SettleCycles = 40;

    typedef struct {
        bit          cmd;
        bit [31:0]   end_a;
        bit [31:0]   end_b;
        bit [31:0]   mask;
        bit          pbit_en;
        bit          pbit_a;
        bit          pbit_b;
        bit [2:0]    idx_bits;
        bit [31:0]   pixel;
        bit          last;
    } request_t;

    typedef struct {
        bit [3:0]    index;
        bit [35:0]   pixel_err;
        bit [43:0]   total_err;
        bit          last;
    } index_result_t;

    // Holds the predicted block state and the results still awaited.
    class index_scoreboard;
        bit [8:0]        weight[4];
        bit [31:0]       qend_a;
        bit [31:0]       qend_b;
        int unsigned     bits;
        bit [43:0]       total;
        index_result_t   pending[$];
        int              fails;
        int unsigned     w2[4]  = '{0, 21, 43, 64};
        int unsigned     w3[8]  = '{0, 9, 18, 27, 37, 46, 55, 64};
        int unsigned     w4[16] = '{0, 4, 9, 13, 17, 21, 26, 30,
                                    34, 38, 43, 47, 51, 55, 60, 64};

        function new();
            foreach (weight[k]) weight[k] = WeightReset;
            qend_a = 0;
            qend_b = 0;
            bits = 2;
            total = 0;
            fails = 0;
        endfunction

        function bit [7:0] quantise(bit [7:0] v, bit [7:0] m, int pbit);
            bit [31:0] prec, step, lo, hi;
            int unsigned dlo, dhi;
            if (m == 8'hFF) return v;
            if (m == 8'h00) return 8'hFF;
            prec = $countones(m);
            step = 32'd1 << (8 - prec);
            lo = {24'd0, v & m};
            hi = lo + step;
            if (pbit >= 0) begin
                prec++;
                lo |= 32'(pbit) << (8 - prec);
                hi |= 32'(pbit) << (8 - prec);
            end
            if (lo > {24'd0, v}) begin
                lo -= step;
                hi -= step;
            end
            lo |= lo >> prec;
            hi |= hi >> prec;
            dlo = (v > lo[7:0]) ? v - lo[7:0] : lo[7:0] - v;
            dhi = (v > hi[7:0]) ? v - hi[7:0] : hi[7:0] - v;
            return (dlo < dhi) ? lo[7:0] : hi[7:0];
        endfunction

        function bit [31:0] quantise_rgba(bit [31:0] px, bit [31:0] m, int pbit);
            bit [31:0] r;
            for (int k = 0; k < 4; k++)
                r[8*k +: 8] = quantise(px[8*k +: 8], m[8*k +: 8], pbit);
            return r;
        endfunction

        function longint unsigned weighted_error(bit [31:0] px, int j);
            int unsigned w1, w0, a, b, ip, p, d;
            longint unsigned e, sum;
            w1 = (bits == 2) ? w2[j & 3] : (bits == 3) ? w3[j & 7] : w4[j & 15];
            w0 = 64 - w1;
            sum = 0;
            for (int k = 0; k < 4; k++) begin
                a = qend_a[8*k +: 8];
                b = qend_b[8*k +: 8];
                p = px[8*k +: 8];
                ip = ((a * w0 + b * w1 + 32) >> 6) & 8'hFF;
                d = (p > ip) ? p - ip : ip - p;
                e = longint'(d) * weight[k];
                sum += e * e;
            end
            return sum;
        endfunction

        function void note_request(request_t r);
            longint dot, lsq, num, q, rem, fl, cl, top, a, b, p;
            longint unsigned err, e2, sum;
            index_result_t res;
            int best;
            if (r.cmd == CmdLoad) begin
                qend_a = quantise_rgba(r.end_a, r.mask, r.pbit_en ? int'(r.pbit_a) : -1);
                qend_b = quantise_rgba(r.end_b, r.mask, r.pbit_en ? int'(r.pbit_b) : -1);
                bits = (r.idx_bits < 2) ? 2 : (r.idx_bits > 4) ? 4 : r.idx_bits;
                total = 0;
                return;
            end
            top = (1 << bits) - 1;
            dot = 0;
            lsq = 0;
            for (int k = 0; k < 4; k++) begin
                a = qend_a[8*k +: 8];
                b = qend_b[8*k +: 8];
                p = r.pixel[8*k +: 8];
                dot += (p - a) * (b - a);
                lsq += (b - a) * (b - a);
            end
            if (lsq == 0) begin
                best = 0;
                err = weighted_error(r.pixel, 0);
            end else begin
                num = dot * top;
                q = num / lsq;
                rem = num % lsq;
                fl = (rem != 0 && num < 0) ? q - 1 : q;
                cl = (rem != 0 && num > 0) ? q + 1 : q;
                if (fl < 0) fl = 0;
                if (fl > top) fl = top;
                if (cl > top) cl = top;
                best = int'(fl);
                err = weighted_error(r.pixel, best);
                if (cl > fl) begin
                    e2 = weighted_error(r.pixel, int'(cl));
                    if (e2 < err) begin
                        err = e2;
                        best = int'(cl);
                    end
                end
            end
            err &= (64'd1 << 36) - 1;
            sum = longint'(total) + err;
            total = (sum > (64'd1 << 44) - 1) ? '1 : sum[43:0];
            res.index = best[3:0];
            res.pixel_err = err[35:0];
            res.total_err = total;
            res.last = r.last;
            pending.push_back(res);
        endfunction

        function void check_result(bit [OutWidth-1:0] data, bit last);
            index_result_t want;
            if (pending.size() == 0) begin
                $error("result with no pixel request outstanding: %h", data);
                fails++;
                return;
            end
            want = pending.pop_front();
            if (data[3:0] != want.index) begin
                $error("index: expected %0d, got %0d", want.index, data[3:0]);
                fails++;
            end
            if (data[39:4] != want.pixel_err) begin
                $error("pixel_error: expected %0d, got %0d", want.pixel_err, data[39:4]);
                fails++;
            end
            if (data[83:40] != want.total_err) begin
                $error("total_error: expected %0d, got %0d", want.total_err, data[83:40]);
                fails++;
            end
            if (last != want.last) begin
                $error("last_out: expected %0d, got %0d", want.last, last);
                fails++;
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [InWidth-1:0]   s_tdata;
    logic                 s_tuser;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OutWidth-1:0]  m_tdata;
    logic                 m_tlast;
    logic                 cfg_we;
    logic [CfgAddrW-1:0]  cfg_addr;
    logic [WeightW-1:0]   cfg_wdata;

    index_scoreboard sb = new();
    bit              no_idle = 0;
    int              results_seen = 0;

    bc7_endpoint_quantize_index_error i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    initial begin
        #20ms;
        $display("tb_bc7_endpoint_quantize_index_error: errors");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off so the block backs up.
    initial begin
        bit held;
        held = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                sb.check_result(m_tdata, m_tlast);
                results_seen++;
            end
            if (!held && results_seen == 150) begin
                held = 1;
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
            end
            m_tready <= no_idle || ($urandom_range(99) >= 32);
        end
    end

    task automatic send_request(request_t r);
        while (!no_idle && $urandom_range(99) < 32) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.cmd;
        s_tlast  <= r.last;
        s_tdata  <= {2'b00, r.pixel, r.idx_bits, r.pbit_b, r.pbit_a, r.pbit_en,
                     r.mask, r.end_b, r.end_a};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(r);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task automatic write_weight(logic [CfgAddrW-1:0] addr, logic [WeightW-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.weight[addr] = value;
    endtask

    task automatic set_weights(bit [8:0] r, bit [8:0] g, bit [8:0] b, bit [8:0] a);
        drain();
        write_weight(RegWeightRed, r);
        write_weight(RegWeightGreen, g);
        write_weight(RegWeightBlue, b);
        write_weight(RegWeightAlpha, a);
    endtask

    function automatic request_t load_req(bit [31:0] ea, bit [31:0] eb, bit [31:0] m,
                                          bit pe, bit pa, bit pb, bit [2:0] nb);
        request_t r;
        r.cmd = CmdLoad;
        r.end_a = ea;
        r.end_b = eb;
        r.mask = m;
        r.pbit_en = pe;
        r.pbit_a = pa;
        r.pbit_b = pb;
        r.idx_bits = nb;
        r.pixel = $urandom;
        r.last = $urandom_range(1);
        return r;
    endfunction

    function automatic request_t pixel_req(bit [31:0] px, bit lst);
        request_t r;
        r.cmd = CmdPixel;
        r.end_a = $urandom;
        r.end_b = $urandom;
        r.mask = $urandom;
        r.pbit_en = $urandom_range(1);
        r.pbit_a = $urandom_range(1);
        r.pbit_b = $urandom_range(1);
        r.idx_bits = $urandom_range(7);
        r.pixel = px;
        r.last = lst;
        return r;
    endfunction

    function automatic bit [7:0] usual_mask();
        bit [7:0] opts[8] = '{8'hFF, 8'h00, 8'hF8, 8'hFC, 8'hF0, 8'hFE, 8'hE0, 8'hC0};
        return ($urandom_range(9) == 0) ? 8'($urandom) : opts[$urandom_range(7)];
    endfunction

    // A load followed by a short run of pixels, with the odd malformed request mixed in.
    task automatic random_blocks(int count);
        request_t r;
        bit [31:0] ea, m;
        int n;
        for (int i = 0; i < count; ) begin
            ea = $urandom;
            for (int k = 0; k < 4; k++) m[8*k +: 8] = usual_mask();
            send_request(load_req(ea, ($urandom_range(7) == 0) ? ea : $urandom, m,
                                  $urandom_range(1), $urandom_range(1), $urandom_range(1),
                                  ($urandom_range(5) == 0) ? 3'($urandom) :
                                  3'($urandom_range(4, 2))));
            i++;
            n = $urandom_range(16, 1);
            for (int p = 0; p < n; p++) begin
                r = pixel_req($urandom, p == n - 1);
                if ($urandom_range(19) == 0) r.cmd = CmdLoad;
                send_request(r);
                i++;
            end
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        s_tlast   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Pixels before any load use the zero endpoints.
        send_request(pixel_req(32'h0000_0000, 1'b0));
        send_request(pixel_req(32'hFFFF_FFFF, 1'b1));
        send_request(load_req(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 3'd4));
        send_request(pixel_req(32'h0000_0000, 1'b0));
        send_request(pixel_req(32'hFFFF_FFFF, 1'b0));
        send_request(pixel_req(32'h8080_8080, 1'b1));
        send_request(load_req(32'h1234_5678, 32'h9ABC_DEF0, 32'h0000_0000, 0, 0, 0, 3'd0));
        send_request(pixel_req(32'h4477_AA11, 1'b1));
        send_request(load_req(32'h0810_2040, 32'hF0E0_C080, 32'hF8FC_F0FE, 1, 0, 1, 3'd1));
        send_request(pixel_req(32'h0000_0000, 1'b0));
        send_request(pixel_req(32'hFFFF_FFFF, 1'b1));
        send_request(load_req(32'h07FF_01FE, 32'hF900_FF03, 32'hAA55_C3E0, 1, 1, 0, 3'd7));
        send_request(pixel_req(32'h3C5A_9601, 1'b0));
        send_request(pixel_req(32'hFF00_FF00, 1'b1));
        send_request(load_req(32'h4060_80A0, 32'h4060_80A0, 32'hFCFC_FCFC, 1, 1, 1, 3'd3));
        send_request(pixel_req(32'h0102_0304, 1'b1));
        send_request(load_req(32'hFF00_FF00, 32'h00FF_00FF, 32'hFFFF_FFFF, 0, 0, 0, 3'd5));
        send_request(pixel_req(32'h7F80_7F80, 1'b0));
        send_request(pixel_req(32'hFFFF_0000, 1'b1));

        set_weights(9'd511, 9'd511, 9'd511, 9'd511);
        // The largest pixel error each time drives the running total into saturation.
        send_request(load_req(32'h0, 32'h0, 32'hFFFF_FFFF, 0, 0, 0, 3'd2));
        for (int i = 0; i < 270; i++)
            send_request(pixel_req(32'hFFFF_FFFF, i == 269));

        set_weights(9'd0, 9'd0, 9'd0, 9'd0);
        random_blocks(60);

        set_weights(9'($urandom), 9'($urandom), 9'($urandom), 9'($urandom));
        no_idle = 1;
        random_blocks(120);
        no_idle = 0;
        random_blocks(150);

        set_weights(9'd256, 9'd1, 9'd128, 9'd511);
        random_blocks(230);

        drain();
        if (sb.fails == 0)
            $display("tb_bc7_endpoint_quantize_index_error: clean");
        else
            $display("tb_bc7_endpoint_quantize_index_error: errors");
        $finish;
    end
endmodule
